[hw/rtl/svou_pkg.sv]
package svou_pkg;

  // Sizing
  localparam int unsigned NUM_CHANNELS     = 8;
  localparam int unsigned VARS_PER_CHANNEL = 26;
  localparam int unsigned DATA_W           = 32;
  localparam int unsigned SID_W            = 16;
  localparam int unsigned WORD_W           = 16;
  localparam int unsigned SLOT_W           = 3;
  localparam int unsigned KIND_W           = 2;
  localparam int unsigned OP_W             = 6;
  localparam int unsigned STAT_W           = 3;
  localparam int unsigned CH_W      = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int unsigned VIX_W     = $clog2(VARS_PER_CHANNEL);
  localparam int unsigned MEM_DEPTH = NUM_CHANNELS * VARS_PER_CHANNEL;
  localparam int unsigned ADDR_W    = $clog2(MEM_DEPTH);
  localparam int unsigned CNT_W     = $clog2(DATA_W);

  // Fixed variable slots
  localparam logic [WORD_W-1:0] CODE_FLAG_INDEX  = 16'd26;
  localparam logic [WORD_W-1:0] TALK_STATE_INDEX = 16'd19;

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_START = 2'd0;
  localparam logic [KIND_W-1:0] KIND_EXEC  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd3;

  // Operations (opcode word bits 11..6)
  localparam logic [OP_W-1:0] OP_CONTINUE = 6'd0;
  localparam logic [OP_W-1:0] OP_TALK     = 6'd4;
  localparam logic [OP_W-1:0] OP_SET      = 6'd8;
  localparam logic [OP_W-1:0] OP_ADD      = 6'd12;
  localparam logic [OP_W-1:0] OP_SUB      = 6'd14;
  localparam logic [OP_W-1:0] OP_MUL      = 6'd16;
  localparam logic [OP_W-1:0] OP_DIV      = 6'd20;
  localparam logic [OP_W-1:0] OP_INC      = 6'd24;
  localparam logic [OP_W-1:0] OP_DEC      = 6'd26;

  // Indirect mode (opcode word bits 5..4) that reads the second operand from a variable
  localparam logic [1:0] IND_MODE_VAR = 2'd2;

  // Result status codes
  localparam logic [STAT_W-1:0] STAT_OK        = 3'd0;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 3'd1;
  localparam logic [STAT_W-1:0] STAT_BAD_INDEX = 3'd2;
  localparam logic [STAT_W-1:0] STAT_ILLEGAL   = 3'd3;
  localparam logic [STAT_W-1:0] STAT_DIV_ZERO  = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_RD_REQ,
    ST_RD_DAT,
    ST_ALU,
    ST_MUL,
    ST_DIV_CHK,
    ST_NEG_X,
    ST_NEG_V,
    ST_DIV,
    ST_DIV_FIX,
    ST_WRITE,
    ST_FINISH
  } svou_state_e;

endpackage

[hw/rtl/svou_if.sv]
interface svou_in_if;
  logic                                valid;
  logic                                ready;
  logic        [svou_pkg::KIND_W-1:0]  kind;
  logic        [svou_pkg::SLOT_W-1:0]  channel;
  logic        [svou_pkg::SID_W-1:0]   sound_id;
  logic                                has_code;
  logic        [svou_pkg::WORD_W-1:0]  opcode_word;
  logic        [svou_pkg::WORD_W-1:0]  first_operand;
  logic        [svou_pkg::WORD_W-1:0]  second_operand;
  logic signed [svou_pkg::DATA_W-1:0]  write_value;

  modport source (output valid, kind, channel, sound_id, has_code, opcode_word,
                  first_operand, second_operand, write_value, input ready);
  modport sink   (input valid, kind, channel, sound_id, has_code, opcode_word,
                  first_operand, second_operand, write_value, output ready);
endinterface

interface svou_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [svou_pkg::DATA_W-1:0]  read_value;
  logic        [svou_pkg::STAT_W-1:0]  status;

  modport source (output valid, read_value, status, input ready);
  modport sink   (input valid, read_value, status, output ready);
endinterface

interface svou_cfg_if;
  logic valid;
  logic ready;
  logic late_version_mode;

  modport source (output valid, late_version_mode, input ready);
  modport sink   (input valid, late_version_mode, output ready);
endinterface

[hw/rtl/sound_variable_opcode_unit.sv]
// Sound variable and opcode unit.
// Channels: in_i carries one item (start a channel, execute one opcode, read or write a
// variable); out_o returns exactly one transfer per item with read_value and status.
// cfg_i writes the late_version_mode bit; it is always ready and must only be written
// while no item is in flight.
// Sequencing: one item at a time; the next item is taken once the current one has
// left its final step. After the input transfer the sequencer walks lookup, up to
// two variable reads (a request and a data step each, registered memory port), then
// the shared 33-bit adder. Multiply and divide each run 32 adder passes (shift-add,
// restoring divide), so the adder loop sets the worst case. The unit returns to idle
// after each result.
// Reset: ids, code flags and the per-variable valid bits clear at once, so every
// variable reads zero; there is no clearing sweep. Mode returns to 0.
// Stall: the result sits in an output register. The unit takes the next item while
// it waits, and only holds in its final step if a second result is ready before the
// receiver took the first.
module sound_variable_opcode_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  svou_cfg_if.sink          cfg_i,
  svou_in_if.sink           in_i,
  svou_out_if.source        out_o
);
  import svou_pkg::*;

  svou_state_e state_q, state_d;

  // Latched item
  logic [KIND_W-1:0] kind_q;
  logic [SLOT_W-1:0] slot_q;
  logic [SID_W-1:0]  sid_q;
  logic              code_q;
  logic [WORD_W-1:0] word_q;
  logic [WORD_W-1:0] a_q;
  logic [WORD_W-1:0] b_q;
  logic [DATA_W-1:0] wv_q;

  // Channel table and variable store
  logic [SID_W-1:0]            sound_q [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0]     flag_q;
  logic [VARS_PER_CHANNEL-1:0] vld_q   [NUM_CHANNELS];
  logic [DATA_W-1:0]           mem     [MEM_DEPTH];
  logic [DATA_W-1:0]           mem_q;
  logic                        late_q;

  // Working registers
  logic [CH_W-1:0]   ch_q;
  logic              found_q;
  logic              rd_sel_q;   // 1: operand A, 0: operand B
  logic              rd_ok_q;
  logic              rd_flag_q;
  logic [DATA_W-1:0] acc_q;
  logic [DATA_W-1:0] opv_q;
  logic [DATA_W-1:0] rem_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [STAT_W-1:0] st_q;
  logic [WORD_W-1:0] tgt_q;
  logic              neg_x_q;
  logic              neg_v_q;

  logic [DATA_W-1:0] out_val_q;
  logic [STAT_W-1:0] out_st_q;
  logic              out_vld_q;

  // Decode
  logic [OP_W-1:0]   op;
  logic              op_legal;
  logic              indirect;
  logic              in_xfer;
  logic              out_load;
  logic              cnt_last;
  logic [CH_W-1:0]   hit_ch;
  logic              hit_found;
  logic [WORD_W-1:0] rd_idx;
  logic              rd_is_flag;
  logic              rd_bad;
  logic              rd_vld;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic              tgt_ok;
  logic              mem_we;
  logic              slot_ok;
  logic [CH_W-1:0]   slot_ix;
  logic [DATA_W-1:0] rd_data;

  // Shared adder
  logic [DATA_W:0]   add_a;
  logic [DATA_W:0]   add_b;
  logic              add_sub;
  logic [DATA_W:0]   add_y;

  assign op       = word_q[11:6];
  assign indirect = (word_q[5:4] == IND_MODE_VAR);
  assign in_xfer  = in_i.valid && in_i.ready;
  assign out_load = (state_q == ST_FINISH) && (!out_vld_q || out_o.ready);
  assign cnt_last = (cnt_q == CNT_W'(DATA_W - 1));

  assign in_i.ready       = (state_q == ST_IDLE);
  assign cfg_i.ready      = 1'b1;
  assign out_o.valid      = out_vld_q;
  assign out_o.read_value = $signed(out_val_q);
  assign out_o.status     = out_st_q;

  always_comb begin
    unique case (op)
      OP_CONTINUE, OP_TALK, OP_SET, OP_ADD, OP_SUB,
      OP_MUL, OP_DIV, OP_INC, OP_DEC: op_legal = 1'b1;
      default:                        op_legal = 1'b0;
    endcase
  end

  // Highest-numbered channel holding the id wins
  always_comb begin
    hit_found = 1'b0;
    hit_ch    = '0;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      if (sound_q[i] == sid_q) begin
        hit_found = 1'b1;
        hit_ch    = CH_W'(i);
      end
    end
  end

  // Variable read: the code flag slot takes precedence over the range check
  assign rd_idx     = rd_sel_q ? a_q : b_q;
  assign rd_is_flag = late_q && (rd_idx == CODE_FLAG_INDEX);
  assign rd_bad     = !rd_is_flag && (rd_idx >= WORD_W'(VARS_PER_CHANNEL));
  assign rd_vld     = rd_is_flag ? flag_q[ch_q] : vld_q[ch_q][rd_idx[VIX_W-1:0]];
  assign rd_addr    = ADDR_W'(ch_q) * ADDR_W'(VARS_PER_CHANNEL)
                    + ADDR_W'(rd_idx[VIX_W-1:0]);
  assign rd_data    = !rd_ok_q ? '0 : (rd_flag_q ? DATA_W'(1) : mem_q);

  assign tgt_ok  = (tgt_q < WORD_W'(VARS_PER_CHANNEL));
  assign wr_addr = ADDR_W'(ch_q) * ADDR_W'(VARS_PER_CHANNEL) + ADDR_W'(tgt_q[VIX_W-1:0]);
  assign mem_we  = (state_q == ST_WRITE) && tgt_ok && found_q;

  assign slot_ok = (32'(slot_q) < NUM_CHANNELS);
  assign slot_ix = CH_W'(slot_q);

  // Operand selection for the one adder
  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_sub = 1'b0;
    unique case (state_q)
      ST_ALU: begin
        add_a = {1'b0, acc_q};
        priority if (op == OP_ADD) begin
          add_b = {17'd0, b_q};
        end else if (op == OP_SUB) begin
          add_b   = {17'd0, b_q};
          add_sub = 1'b1;
        end else if (op == OP_INC) begin
          add_b = (DATA_W + 1)'(1);
        end else begin
          add_b   = (DATA_W + 1)'(1);
          add_sub = 1'b1;
        end
      end
      ST_MUL: begin
        add_a = {1'b0, rem_q};
        add_b = opv_q[0] ? {1'b0, acc_q} : '0;
      end
      ST_NEG_X, ST_DIV_FIX: begin
        add_b   = {1'b0, acc_q};
        add_sub = 1'b1;
      end
      ST_NEG_V: begin
        add_b   = {1'b0, opv_q};
        add_sub = 1'b1;
      end
      ST_DIV: begin
        add_a   = {rem_q, acc_q[DATA_W-1]};
        add_b   = {1'b0, opv_q};
        add_sub = 1'b1;
      end
      default: begin
        add_sub = 1'b0;
      end
    endcase
  end

  assign add_y = add_a + (add_sub ? ~add_b : add_b) + (DATA_W + 1)'(add_sub);

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) state_d = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        unique case (kind_q)
          KIND_START: state_d = ST_FINISH;
          KIND_WRITE: state_d = ST_WRITE;
          KIND_READ:  state_d = ST_RD_REQ;
          KIND_EXEC: begin
            unique case (op)
              OP_CONTINUE: state_d = ST_FINISH;
              OP_TALK:     state_d = ST_WRITE;
              OP_SET:      state_d = indirect ? ST_RD_REQ : ST_WRITE;
              OP_ADD, OP_SUB, OP_INC, OP_DEC,
              OP_MUL, OP_DIV: state_d = ST_RD_REQ;
              default:     state_d = ST_FINISH;
            endcase
          end
        endcase
      end
      ST_RD_REQ: begin
        state_d = rd_bad ? ST_FINISH : ST_RD_DAT;
      end
      ST_RD_DAT: begin
        priority if (!rd_sel_q) begin
          state_d = (op == OP_SET) ? ST_WRITE : ST_RD_REQ;
        end else if (kind_q == KIND_READ) begin
          state_d = ST_FINISH;
        end else if (op == OP_MUL) begin
          state_d = ST_MUL;
        end else if (op == OP_DIV) begin
          state_d = ST_DIV_CHK;
        end else begin
          state_d = ST_ALU;
        end
      end
      ST_ALU:     state_d = ST_WRITE;
      ST_MUL:     if (cnt_last) state_d = ST_WRITE;
      ST_DIV_CHK: state_d = (opv_q == '0) ? ST_FINISH : ST_NEG_X;
      ST_NEG_X:   state_d = ST_NEG_V;
      ST_NEG_V:   state_d = ST_DIV;
      ST_DIV:     if (cnt_last) state_d = ST_DIV_FIX;
      ST_DIV_FIX: state_d = ST_WRITE;
      ST_WRITE:   state_d = ST_FINISH;
      ST_FINISH:  if (out_load) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      out_vld_q <= 1'b0;
      late_q    <= 1'b0;
      flag_q    <= '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        sound_q[i] <= '0;
        vld_q[i]   <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_i.valid) late_q <= cfg_i.late_version_mode;
      // Start: take the id and flag, drop every variable of the slot back to zero
      if (state_q == ST_LOOKUP && kind_q == KIND_START && slot_ok) begin
        sound_q[slot_ix] <= sid_q;
        flag_q[slot_ix]  <= code_q;
        vld_q[slot_ix]   <= '0;
      end
      if (mem_we) vld_q[ch_q][tgt_q[VIX_W-1:0]] <= 1'b1;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Variable store, one read and one write port
  always_ff @(posedge clk_i) begin
    if (state_q == ST_RD_REQ && !rd_is_flag && !rd_bad) mem_q <= mem[rd_addr];
    if (mem_we) mem[wr_addr] <= acc_q;
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      kind_q <= in_i.kind;
      slot_q <= in_i.channel;
      sid_q  <= in_i.sound_id;
      code_q <= in_i.has_code;
      word_q <= in_i.opcode_word;
      a_q    <= in_i.first_operand;
      b_q    <= in_i.second_operand;
      wv_q   <= $unsigned(in_i.write_value);
    end
    if (out_load) begin
      out_val_q <= (st_q == STAT_OK) ? acc_q : '0;
      out_st_q  <= st_q;
    end
    unique case (state_q)
      ST_LOOKUP: begin
        ch_q     <= hit_ch;
        found_q  <= hit_found;
        st_q     <= (kind_q == KIND_EXEC && !op_legal) ? STAT_ILLEGAL : STAT_OK;
        opv_q    <= {16'd0, b_q};
        rem_q    <= '0;
        cnt_q    <= '0;
        tgt_q    <= (kind_q == KIND_EXEC && op == OP_TALK) ? TALK_STATE_INDEX : a_q;
        // Indirect second operand is fetched first for set, multiply, divide
        rd_sel_q <= !(kind_q == KIND_EXEC && indirect
                      && (op == OP_SET || op == OP_MUL || op == OP_DIV));
        priority if (kind_q == KIND_WRITE) begin
          acc_q <= wv_q;
        end else if (kind_q == KIND_EXEC && op == OP_TALK) begin
          acc_q <= {16'd0, a_q};
        end else if (kind_q == KIND_EXEC && op == OP_SET) begin
          acc_q <= {16'd0, b_q};
        end else begin
          acc_q <= '0;
        end
      end
      ST_RD_REQ: begin
        rd_flag_q <= rd_is_flag;
        rd_ok_q   <= found_q && rd_vld;
        if (rd_bad) st_q <= STAT_BAD_INDEX;
      end
      ST_RD_DAT: begin
        acc_q    <= rd_data;
        rd_sel_q <= 1'b1;
        if (!rd_sel_q) opv_q <= rd_data;
        if (rd_sel_q && kind_q == KIND_READ && !found_q) st_q <= STAT_NOT_FOUND;
      end
      ST_ALU: acc_q <= add_y[DATA_W-1:0];
      ST_MUL: begin
        // Shift-add: partial product in rem, multiplicand in acc, multiplier in opv
        rem_q <= add_y[DATA_W-1:0];
        acc_q <= cnt_last ? add_y[DATA_W-1:0] : {acc_q[DATA_W-2:0], 1'b0};
        opv_q <= {1'b0, opv_q[DATA_W-1:1]};
        cnt_q <= cnt_q + CNT_W'(1);
      end
      ST_DIV_CHK: begin
        if (opv_q == '0) st_q <= STAT_DIV_ZERO;
        neg_x_q <= acc_q[DATA_W-1];
        neg_v_q <= opv_q[DATA_W-1];
      end
      ST_NEG_X: if (neg_x_q) acc_q <= add_y[DATA_W-1:0];
      ST_NEG_V: if (neg_v_q) opv_q <= add_y[DATA_W-1:0];
      ST_DIV: begin
        // Restoring step: keep the difference when it did not borrow, else the shifted
        // remainder
        rem_q <= add_y[DATA_W] ? add_a[DATA_W-1:0] : add_y[DATA_W-1:0];
        acc_q <= {acc_q[DATA_W-2:0], !add_y[DATA_W]};
        cnt_q <= cnt_q + CNT_W'(1);
      end
      ST_DIV_FIX: if (neg_x_q ^ neg_v_q) acc_q <= add_y[DATA_W-1:0];
      ST_WRITE: begin
        if (!tgt_ok) begin
          st_q <= STAT_BAD_INDEX;
        end else if (!found_q) begin
          st_q <= STAT_NOT_FOUND;
        end
      end
      default: begin
        cnt_q <= cnt_q;
      end
    endcase
  end

endmodule

[hw/rtl/svou_checker.sv]
module svou_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [svou_pkg::DATA_W-1:0]   out_value_i,
  input logic [svou_pkg::STAT_W-1:0]   out_status_i
);
  import svou_pkg::*;

  // A result that waits keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_value_i)
                                    && $stable(out_status_i))
    else $error("stalled result changed");

  // One item at a time: no second transfer right behind the first
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input accepted while busy");

  // A failed item never carries a value
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_status_i != STAT_OK) |-> (out_value_i == '0))
    else $error("nonzero value with error status");

  // A fresh result comes from the final step, when no input is taken
  a_result_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result appeared without a finished item");

endmodule

bind sound_variable_opcode_unit svou_checker u_svou_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_value_i  (out_o.read_value),
  .out_status_i (out_o.status)
);
